/* design/tgs_pkg.sv */
// shared constants and types for the telegraph gene stochastic step block
// no dependencies
package tgs_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TIME_W      = 48;
  localparam int RATE_W      = 32;
  localparam int TOT_W       = RATE_W + 2;
  localparam int NL_W        = 38;
  localparam int CNT_W       = 6;

  localparam logic [RATE_W-1:0] LN2_Q32  = 32'd2977044472;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // reaction codes
  localparam logic [2:0] RX_ON   = 3'd0;
  localparam logic [2:0] RX_OFF  = 3'd1;
  localparam logic [2:0] RX_SYN  = 3'd2;
  localparam logic [2:0] RX_DEG  = 3'd3;
  localparam logic [2:0] RX_NONE = 3'd4;

  // status codes
  localparam logic [1:0] ST_STEP = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ON  = 3'd0;
  localparam logic [2:0] REG_OFF = 3'd1;
  localparam logic [2:0] REG_SYN = 3'd2;
  localparam logic [2:0] REG_DEG = 3'd3;
  localparam logic [2:0] REG_END = 3'd4;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHK   = 7'b0000010,
    S_SQR   = 7'b0000100,
    S_LNMUL = 7'b0001000,
    S_LNSUM = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

endpackage

/* design/telegraph_gillespie_step.sv */
// telegraph gene model, one stochastic simulation step per request
// depends on tgs_pkg
//
// usage: the input channel carries restart and two uniform fractions; each
// request yields exactly one result on the output channel (gene state, count,
// time, reaction and status). rates and end time sit in an APB register file
// at byte addresses 8*i, 64-bit data; the user must write them only while the
// block is idle, and the block itself does not enforce it. a normal step runs
// from accept to the result register through propensities and checks, 32 squaring
// passes of a 32x32 multiplier for the logarithm, the ln2 and pick products,
// a restoring divider over 38 quotient bits at one bit per cycle, then commit.
// a zero wait fraction skips the divider; restart, end reached and zero
// propensity go from the checks straight to the commit.
// one request is in flight at a time; in_stall stays high until the result is
// registered, so no new request is taken before the last result is registered.
// the result register holds while out_stall is high, and a finished step waits
// for it; the next request may be accepted while a result still waits.
// reset (rst_n low, synchronous) returns rates to 1.0, end time to 100.0,
// gene off, count zero and time zero, and drops out_valid.
module telegraph_gillespie_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  input  logic [31:0] in_uniform_wait,
  input  logic [31:0] in_uniform_pick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_gene_is_on,
  output logic [15:0] out_product_count,
  output logic [47:0] out_time_now,
  output logic [2:0]  out_reaction_fired,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import tgs_pkg::*;

  state_t state_r;

  logic [RATE_W-1:0] ron_r, roff_r, rsyn_r, rdeg_r;
  logic [TIME_W-1:0] end_r;

  logic                   active_r;
  logic [COUNT_WIDTH-1:0] level_r;
  logic [TIME_W-1:0]      time_r;

  logic              restart_r;
  logic [31:0]       wait_r, pick_r;
  logic [TOT_W-1:0]  cum0_r, cum1_r, cum2_r, tot_r;
  logic [1:0]        kind_r;
  logic              special_r;
  logic [4:0]        msb_r;
  logic [31:0]       m_r, frac_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [5:0]        hi_r;
  logic [63:0]       plo_r, ppick_r;
  logic [2:0]        rx_r;
  logic [NL_W-1:0]   q_r;
  logic [TOT_W-1:0]  rem_r;

  logic        out_valid_r, gene_o_r;
  logic [15:0] cnt_o_r;
  logic [47:0] time_o_r;
  logic [2:0]  rx_o_r;
  logic [1:0]  st_o_r;

  // register file
  logic       wr_en;
  logic [2:0] reg_idx;
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ron_r  <= 32'd65536;
      roff_r <= 32'd65536;
      rsyn_r <= 32'd65536;
      rdeg_r <= 32'd65536;
      end_r  <= 48'd6553600;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ON:  ron_r  <= pwdata[31:0];
        REG_OFF: roff_r <= pwdata[31:0];
        REG_SYN: rsyn_r <= pwdata[31:0];
        REG_DEG: rdeg_r <= pwdata[31:0];
        REG_END: end_r  <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ON:  prdata = {32'd0, ron_r};
      REG_OFF: prdata = {32'd0, roff_r};
      REG_SYN: prdata = {32'd0, rsyn_r};
      REG_DEG: prdata = {32'd0, rdeg_r};
      REG_END: prdata = {16'd0, end_r};
      default: prdata = 64'd0;
    endcase
  end

  // propensities and cumulative sums
  logic [TOT_W-1:0] p0, p1, p2, c1, c2, tot;
  always_comb begin
    p0 = active_r ? '0 : {2'b00, ron_r};
    p1 = active_r ? {2'b00, roff_r} : '0;
    p2 = active_r ? {2'b00, rsyn_r} : '0;
    c1 = p0 + p1;
    c2 = c1 + p2;
    tot = c2 + {2'b00, rdeg_r};
  end

  // leading one of the wait fraction
  logic [4:0] msb;
  always_comb begin
    msb = 5'd0;
    for (int i = 1; i < 32; i++) begin
      if (wait_r[i]) msb = 5'(i);
    end
  end

  // one squaring pass of the log2 fraction
  logic [63:0] sq;
  logic [32:0] sq_s;
  assign sq   = {32'd0, m_r} * {32'd0, m_r};
  assign sq_s = sq[63:31];

  // -log2 in Q.32, split for the ln2 product
  logic [NL_W-1:0] neg;
  assign neg = {6'(6'd32 - {1'b0, msb_r}), 32'd0} - {6'd0, frac_r};

  // ln2 scaling, pick scaling and reaction choice
  logic [NL_W-1:0]  nl;
  logic [TOT_W:0]   scaled;
  logic [2:0]       rx_sel;
  always_comb begin
    nl = NL_W'({32'd0, hi_r} * {6'd0, LN2_Q32}) + {6'd0, plo_r[63:32]};
    scaled = (TOT_W+1)'({2'd0, pick_r} * {32'd0, tot_r[TOT_W-1:RATE_W]})
           + {3'd0, ppick_r[63:32]};
    if (scaled < {1'b0, cum0_r})      rx_sel = RX_ON;
    else if (scaled < {1'b0, cum1_r}) rx_sel = RX_OFF;
    else if (scaled < {1'b0, cum2_r}) rx_sel = RX_SYN;
    else                              rx_sel = RX_DEG;
  end

  // restoring divider step
  logic [TOT_W:0] trial;
  logic           fits;
  assign trial = {rem_r, q_r[NL_W-1]};
  assign fits  = trial >= {1'b0, tot_r};

  // commit of the step
  logic                   out_free;
  logic                   act_n;
  logic [COUNT_WIDTH-1:0] lvl_n;
  logic [TIME_W-1:0]      time_n;
  logic [TIME_W:0]        tsum;
  logic [TIME_W-1:0]      tau;
  assign out_free = !out_valid_r || !out_stall;
  always_comb begin
    act_n  = active_r;
    lvl_n  = level_r;
    time_n = time_r;
    tau    = (wait_r == 32'd0) ? TIME_MAX : TIME_W'(q_r);
    tsum   = {1'b0, time_r} + {1'b0, tau};
    if (restart_r) begin
      act_n  = 1'b0;
      lvl_n  = '0;
      time_n = '0;
    end else if (!special_r) begin
      case (rx_r)
        RX_ON:  act_n = 1'b1;
        RX_OFF: act_n = 1'b0;
        RX_SYN: if (level_r != {COUNT_WIDTH{1'b1}}) lvl_n = level_r + 1'b1;
        default: if (level_r != '0) lvl_n = level_r - 1'b1;
      endcase
      time_n = (tsum[TIME_W] || wait_r == 32'd0) ? TIME_MAX : tsum[TIME_W-1:0];
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
      level_r  <= '0;
      time_r   <= '0;
      cnt_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            restart_r <= in_restart;
            wait_r    <= in_uniform_wait;
            pick_r    <= in_uniform_pick;
            state_r   <= S_CHK;
          end
        end
        S_CHK: begin
          cum0_r <= p0;
          cum1_r <= c1;
          cum2_r <= c2;
          tot_r  <= tot;
          msb_r  <= msb;
          m_r    <= wait_r << (5'd31 - msb);
          frac_r <= '0;
          cnt_r  <= '0;
          if (restart_r) begin
            kind_r <= ST_STEP; special_r <= 1'b1; state_r <= S_FIN;
          end else if (time_r >= end_r) begin
            kind_r <= ST_END; special_r <= 1'b1; state_r <= S_FIN;
          end else if (tot == '0) begin
            kind_r <= ST_ZERO; special_r <= 1'b1; state_r <= S_FIN;
          end else begin
            kind_r <= ST_STEP; special_r <= 1'b0; state_r <= S_SQR;
          end
        end
        S_SQR: begin
          frac_r <= {frac_r[30:0], sq_s[32]};
          m_r    <= sq_s[32] ? sq_s[32:1] : sq_s[31:0];
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(31)) state_r <= S_LNMUL;
        end
        S_LNMUL: begin
          hi_r    <= neg[NL_W-1:32];
          plo_r   <= {32'd0, neg[31:0]} * {32'd0, LN2_Q32};
          ppick_r <= {32'd0, pick_r} * {32'd0, tot_r[RATE_W-1:0]};
          state_r <= S_LNSUM;
        end
        S_LNSUM: begin
          rx_r  <= rx_sel;
          q_r   <= nl;
          rem_r <= '0;
          cnt_r <= '0;
          state_r <= (wait_r == 32'd0) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          rem_r <= fits ? TOT_W'(trial - {1'b0, tot_r}) : trial[TOT_W-1:0];
          q_r   <= {q_r[NL_W-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NL_W - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            active_r <= act_n;
            level_r  <= lvl_n;
            time_r   <= time_n;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
      gene_o_r    <= act_n;
      cnt_o_r     <= 16'(lvl_n);
      time_o_r    <= time_n;
      rx_o_r      <= special_r ? RX_NONE : rx_r;
      st_o_r      <= kind_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_gene_is_on     = gene_o_r;
  assign out_product_count  = cnt_o_r;
  assign out_time_now       = time_o_r;
  assign out_reaction_fired = rx_o_r;
  assign out_status         = st_o_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CHK))
    else $error("accepted request did not start");
  a_special_no_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_STEP) |-> (out_reaction_fired == RX_NONE))
    else $error("end or zero status with a reaction");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(NL_W)))
    else $error("divider ran past its width");
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < tot_r))
    else $error("divider remainder not below divisor");
`endif

endmodule

/* dv/tb_telegraph_gillespie_step.sv */
// testbench for telegraph_gillespie_step: random and directed stochastic step requests,
// checked against an in-bench fixed-point predictor; depends on tgs_pkg and the block
module tb_telegraph_gillespie_step;
  import tgs_pkg::*;

  typedef struct {
    logic        restart;
    logic [31:0] wait_u;
    logic [31:0] pick_u;
  } step_req_t;

  typedef struct {
    logic        gene;
    logic [15:0] count;
    logic [47:0] tnow;
    logic [2:0]  rx;
    logic [1:0]  st;
  } step_res_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_restart;
  logic [31:0] in_uniform_wait, in_uniform_pick;
  logic        out_valid, out_stall, out_gene_is_on;
  logic [15:0] out_product_count;
  logic [47:0] out_time_now;
  logic [2:0]  out_reaction_fired;
  logic [1:0]  out_status;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;

  telegraph_gillespie_step dut (.*);

  // model state and register copies
  logic [63:0] k_on, k_off, k_syn, k_deg, t_end;
  logic        gene_st;
  logic [63:0] level_st, time_st;

  step_req_t   pending_reqs[$];
  step_res_t   expected_steps[$];
  int          send_idle_pct, recv_stall_pct;
  int          mismatches, quiet_cycles;
  logic        req_taken, hold_go, hold_done;
  int          hold_cnt;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // -ln(w/2^32) in Q.32, w nonzero
  function automatic logic [63:0] neg_ln(input logic [31:0] w);
    int          msb;
    logic [63:0] m, frac, neg;
    msb = 31;
    while (msb > 0 && w[msb] == 1'b0) msb--;
    m = 64'(w) << (31 - msb);
    frac = 0;
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    neg = (64'(32 - msb) << 32) - frac;
    return (neg >> 32) * 64'(LN2_Q32) + (((neg & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32);
  endfunction

  // one stochastic step on the model state
  function automatic step_res_t predict_step(input step_req_t r);
    step_res_t   res;
    logic [63:0] p[4];
    logic [63:0] total, tau, scaled, cum, t;
    logic [2:0]  rx;
    rx = RX_NONE;
    res.st = ST_STEP;
    if (r.restart) begin
      gene_st = 0; level_st = 0; time_st = 0;
    end else if (time_st >= t_end) begin
      res.st = ST_END;
    end else begin
      p[0] = gene_st ? 64'd0 : k_on;
      p[1] = gene_st ? k_off : 64'd0;
      p[2] = gene_st ? k_syn : 64'd0;
      p[3] = k_deg;
      total = p[0] + p[1] + p[2] + p[3];
      if (total == 0) begin
        res.st = ST_ZERO;
      end else begin
        tau = (r.wait_u == 0) ? 64'(TIME_MAX) : neg_ln(r.wait_u) / total;
        scaled = 64'(r.pick_u) * (total >> 32)
               + ((64'(r.pick_u) * (total & 64'hFFFF_FFFF)) >> 32);
        rx = RX_DEG;
        cum = 0;
        for (int i = 0; i < 4; i++) begin
          cum += p[i];
          if (scaled < cum) begin
            rx = 3'(i);
            break;
          end
        end
        case (rx)
          RX_ON:  gene_st = 1;
          RX_OFF: gene_st = 0;
          RX_SYN: if (level_st < 64'hFFFF) level_st++;
          default: if (level_st > 0) level_st--;
        endcase
        t = time_st + tau;
        if (tau >= 64'(TIME_MAX) || t > 64'(TIME_MAX)) t = 64'(TIME_MAX);
        time_st = t;
      end
    end
    res.gene = gene_st;
    res.count = level_st[15:0];
    res.tnow = time_st[47:0];
    res.rx = rx;
    return res;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        step_req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_restart <= r.restart;
        in_uniform_wait <= r.wait_u;
        in_uniform_pick <= r.pick_u;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 500) hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("tb: failure");
        $finish;
      end
      if (in_valid && !in_stall) begin
        step_req_t r;
        r.restart = in_restart;
        r.wait_u = in_uniform_wait;
        r.pick_u = in_uniform_pick;
        expected_steps.push_back(predict_step(r));
      end
      if (out_valid && !out_stall) begin
        step_res_t e;
        if (expected_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at %0t", $time);
        end else begin
          e = expected_steps.pop_front();
          if (e.gene !== out_gene_is_on || e.count !== out_product_count ||
              e.tnow !== out_time_now || e.rx !== out_reaction_fired ||
              e.st !== out_status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp g%0d n%0d t%h r%0d s%0d got g%0d n%0d t%h r%0d s%0d",
                       e.gene, e.count, e.tnow, e.rx, e.st, out_gene_is_on,
                       out_product_count, out_time_now, out_reaction_fired, out_status);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 6'(idx) << 3; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_ON:  k_on = val & 64'hFFFF_FFFF;
      REG_OFF: k_off = val & 64'hFFFF_FFFF;
      REG_SYN: k_syn = val & 64'hFFFF_FFFF;
      REG_DEG: k_deg = val & 64'hFFFF_FFFF;
      default: t_end = val & 64'(TIME_MAX);
    endcase
  endtask

  task automatic set_rates(input logic [31:0] a, b, c, d, input logic [47:0] te);
    write_reg(REG_ON, 64'(a));
    write_reg(REG_OFF, 64'(b));
    write_reg(REG_SYN, 64'(c));
    write_reg(REG_DEG, 64'(d));
    write_reg(REG_END, 64'(te));
  endtask

  task automatic queue_step(input logic rs, input logic [31:0] w, p);
    step_req_t r;
    r.restart = rs; r.wait_u = w; r.pick_u = p;
    pending_reqs.push_back(r);
  endtask

  task automatic drain;
    wait (pending_reqs.size() == 0 && !in_valid && expected_steps.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_frac;
    case ($urandom_range(9))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_rate;
    case ($urandom_range(5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(16);
      default: return $urandom_range(32'h0008_0000);
    endcase
  endfunction

  initial begin
    rst_n = 0; in_valid = 0; in_restart = 0; in_uniform_wait = 0; in_uniform_pick = 0;
    out_stall = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    req_taken = 0; hold_go = 0; hold_done = 0; hold_cnt = 0;
    mismatches = 0; quiet_cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
    k_on = 65536; k_off = 65536; k_syn = 65536; k_deg = 65536; t_end = 6553600;
    gene_st = 0; level_st = 0; time_st = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // directed: degradation at zero count, pick extremes, wait extremes
    queue_step(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_step(0, 32'h1, 32'h0);
    queue_step(0, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_step(0, 32'hFFFF_FFFF, 32'h0);
    queue_step(0, 32'h0000_0001, 32'h4000_0000);
    // zero wait saturates time, then end reached
    queue_step(0, 32'h0, 32'h1234_5678);
    queue_step(0, 32'hDEAD_BEEF, 32'h0);
    queue_step(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_step(0, 32'h0, 32'h0);
    queue_step(1, 32'h0, 32'h0);
    drain();

    // zero total propensity
    set_rates(0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
    queue_step(0, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_step(0, 32'h0, 32'hFFFF_FFFF);
    drain();
    // synthesis only path, off and on via extreme rates
    set_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    queue_step(0, 32'h1, 32'h1);
    queue_step(1, 32'h1, 32'h1);
    drain();
    write_reg(REG_END, 64'(48'hFFFF_FFFF_FFFF));
    queue_step(0, 32'h1, 32'h0);
    queue_step(0, 32'hFFFF_FFFF, 32'hBFFF_FFFF);
    queue_step(0, 32'h7FFF_FFFF, 32'h9000_0000);
    queue_step(0, 32'h0, 32'h8000_0000);
    queue_step(0, 32'hFFFF_FFFF, 32'h1);
    drain();

    // random phases, each with its own rates and idling
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct  = (ph % 4 == 1) ? 47 : (ph % 4 == 3) ? 28 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 47 : (ph % 4 == 3) ? 28 : 0;
      if (ph == 0)
        set_rates(65536, 65536, 65536, 65536, 6553600);
      else if (ph == 1)
        set_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  48'hFFFF_FFFF_FFFF);
      else if (ph == 2)
        set_rates(1, 1, 1, 0, 48'h0000_0010_0000);
      else
        set_rates(rand_rate(), rand_rate(), rand_rate(), rand_rate(),
                  ($urandom_range(3) == 0) ? 48'hFFFF_FFFF_FFFF
                                           : {16'h0, $urandom_range(32'h00FF_FFFF)});
      // long receiver hold-off while requests keep coming
      if (ph == 4) hold_go = 1;
      for (int i = 0; i < 215; i++)
        queue_step($urandom_range(39) == 0, rand_frac(), rand_frac());
      drain();
    end

    if (mismatches == 0 && expected_steps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* files.f */
design/tgs_pkg.sv
design/telegraph_gillespie_step.sv
dv/tb_telegraph_gillespie_step.sv
